>>> rtl/core/overflow_checked_mul_div_u64_core_defines.svh
// assertion helpers shared by the core
`ifndef OVERFLOW_CHECKED_MUL_DIV_U64_CORE_DEFINES_SVH
`define OVERFLOW_CHECKED_MUL_DIV_U64_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OCMD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OCMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ocmd_pkg.sv
package ocmd_pkg;

    // fixed width of every payload field
    localparam int FIELD_W = 64;

    // per-stage control travelling down the chain
    typedef struct packed {
        logic valid;
        logic fail;
    } t_ctl;

endpackage

>>> rtl/core/ocmd_if.sv
// operand channel
interface ocmd_req_if;
    logic                         valid;
    logic                         ready;
    logic [ocmd_pkg::FIELD_W-1:0] dividend_value;
    logic [ocmd_pkg::FIELD_W-1:0] scale_multiplier;
    logic [ocmd_pkg::FIELD_W-1:0] divisor;

    modport source (output valid, dividend_value, scale_multiplier, divisor, input ready);
    modport sink   (input valid, dividend_value, scale_multiplier, divisor, output ready);
endinterface

// result channel
interface ocmd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ocmd_pkg::FIELD_W-1:0] quotient;
    logic                         success;

    modport source (output valid, quotient, success, input ready);
    modport sink   (input valid, quotient, success, output ready);
endinterface

>>> rtl/core/ocmd_div_cell.sv
// one restoring division step: brings in one dividend bit, yields one quotient bit
module ocmd_div_cell #(
    parameter int W   = 64,
    parameter int BIT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  ocmd_pkg::t_ctl   i_ctl,
    input  logic [W-1:0]     i_val,
    input  logic [W-1:0]     i_mul,
    input  logic [W-1:0]     i_den,
    input  logic [W-1:0]     i_rem,
    input  logic [W-1:0]     i_quo,
    output ocmd_pkg::t_ctl   o_ctl,
    output logic [W-1:0]     o_val,
    output logic [W-1:0]     o_mul,
    output logic [W-1:0]     o_den,
    output logic [W-1:0]     o_rem,
    output logic [W-1:0]     o_quo
);
    import ocmd_pkg::*;

    logic [W:0]   trial;
    logic         ge;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_quo;
    t_ctl         r_ctl;
    logic [W-1:0] r_val, r_mul, r_den, r_rem, r_quo;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {i_rem, i_val[BIT]};
        ge    = (trial >= {1'b0, i_den});
        n_rem = ge ? W'(trial - {1'b0, i_den}) : trial[W-1:0];
        n_quo = {i_quo[W-2:0], ge};
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= i_val;
            r_mul <= i_mul;
            r_den <= i_den;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_val = r_val;
    assign o_mul = r_mul;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule

>>> rtl/core/ocmd_scale_cell.sv
// one multiplier bit: double the running quotient and remainder modulo den, then add the whole and part if set
module ocmd_scale_cell #(
    parameter int W   = 64,
    parameter int BIT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  ocmd_pkg::t_ctl   i_ctl,
    input  logic [W-1:0]     i_mul,
    input  logic [W-1:0]     i_den,
    input  logic [W-1:0]     i_whole,
    input  logic [W-1:0]     i_part,
    input  logic [W-1:0]     i_run,
    input  logic [W-1:0]     i_q,
    output ocmd_pkg::t_ctl   o_ctl,
    output logic [W-1:0]     o_mul,
    output logic [W-1:0]     o_den,
    output logic [W-1:0]     o_whole,
    output logic [W-1:0]     o_part,
    output logic [W-1:0]     o_run,
    output logic [W-1:0]     o_q
);
    import ocmd_pkg::*;

    logic [W-1:0] gap1, run1, gap2, n_run;
    logic         c1, c2, ovf1;
    logic [W-1:0] q1;
    logic [W:0]   sum2;
    logic [W-1:0] n_q;
    t_ctl         n_ctl;
    t_ctl         r_ctl;
    logic [W-1:0] r_mul, r_den, r_whole, r_part, r_run, r_q;

    // doubling step, then conditional add of whole and part
    always_comb begin
        gap1  = i_den - i_run;
        c1    = (i_run >= gap1);
        run1  = c1 ? (i_run - gap1) : (i_run + i_run);
        ovf1  = i_q[W-1];
        q1    = {i_q[W-2:0], c1};
        gap2  = i_den - i_part;
        c2    = (run1 >= gap2);
        sum2  = {1'b0, q1} + {1'b0, i_whole} + {{W{1'b0}}, c2};
        n_run = run1;
        n_q   = q1;
        n_ctl = i_ctl;
        n_ctl.fail = i_ctl.fail | ovf1;
        if (i_mul[BIT]) begin
            n_run = c2 ? (run1 - gap2) : (run1 + i_part);
            n_q   = sum2[W-1:0];
            n_ctl.fail = i_ctl.fail | ovf1 | sum2[W];
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mul   <= i_mul;
            r_den   <= i_den;
            r_whole <= i_whole;
            r_part  <= i_part;
            r_run   <= n_run;
            r_q     <= n_q;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_mul   = r_mul;
    assign o_den   = r_den;
    assign o_whole = r_whole;
    assign o_part  = r_part;
    assign o_run   = r_run;
    assign o_q     = r_q;
endmodule

>>> rtl/core/overflow_checked_mul_div_u64_core.sv
// throughput: one operation per cycle while the result is not stalled; DATA_WIDTH division
//   cells then DATA_WIDTH scaling cells, each cell one register stage
// a stalled result freezes the whole chain until it is taken
// reset: synchronous active-low, clears every stage valid and holds input ready low
module overflow_checked_mul_div_u64_core #(
    parameter int DATA_WIDTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ocmd_req_if.sink   i_req,
    ocmd_rsp_if.source o_rsp
);
    import ocmd_pkg::*;
    `include "overflow_checked_mul_div_u64_core_defines.svh"

    localparam int W = DATA_WIDTH;

    logic en;
    t_ctl         dc   [0:W];
    logic [W-1:0] dval [0:W];
    logic [W-1:0] dmul [0:W];
    logic [W-1:0] dden [0:W];
    logic [W-1:0] drem [0:W];
    logic [W-1:0] dquo [0:W];
    t_ctl         sc   [0:W];
    logic [W-1:0] smul [0:W];
    logic [W-1:0] sden [0:W];
    logic [W-1:0] swh  [0:W];
    logic [W-1:0] spt  [0:W];
    logic [W-1:0] srun [0:W];
    logic [W-1:0] sq   [0:W];

    // chain advances whenever the last stage is empty or being taken
    assign en          = !sc[W].valid || o_rsp.ready;
    assign i_req.ready = en && i_rst_n;

    // chain head
    always_comb begin
        dval[0]     = i_req.dividend_value[W-1:0];
        dmul[0]     = i_req.scale_multiplier[W-1:0];
        dden[0]     = i_req.divisor[W-1:0];
        drem[0]     = '0;
        dquo[0]     = '0;
        dc[0].valid = i_req.valid;
        dc[0].fail  = (i_req.divisor[W-1:0] == '0);
    end

    // division cells: value / divisor, msb first
    for (genvar k = 0; k < W; k++) begin : g_div
        ocmd_div_cell #(.W(W), .BIT(W-1-k)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(dc[k]), .i_val(dval[k]), .i_mul(dmul[k]), .i_den(dden[k]),
            .i_rem(drem[k]), .i_quo(dquo[k]),
            .o_ctl(dc[k+1]), .o_val(dval[k+1]), .o_mul(dmul[k+1]), .o_den(dden[k+1]),
            .o_rem(drem[k+1]), .o_quo(dquo[k+1])
        );
    end

    // hand off from division to scaling
    always_comb begin
        sc[0]   = dc[W];
        smul[0] = dmul[W];
        sden[0] = dden[W];
        swh[0]  = dquo[W];
        spt[0]  = drem[W];
        srun[0] = '0;
        sq[0]   = '0;
    end

    // scaling cells: multiplier bits, msb first
    for (genvar k = 0; k < W; k++) begin : g_scale
        ocmd_scale_cell #(.W(W), .BIT(W-1-k)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(sc[k]), .i_mul(smul[k]), .i_den(sden[k]), .i_whole(swh[k]),
            .i_part(spt[k]), .i_run(srun[k]), .i_q(sq[k]),
            .o_ctl(sc[k+1]), .o_mul(smul[k+1]), .o_den(sden[k+1]), .o_whole(swh[k+1]),
            .o_part(spt[k+1]), .o_run(srun[k+1]), .o_q(sq[k+1])
        );
    end

    // result
    assign o_rsp.valid    = sc[W].valid;
    assign o_rsp.success  = !sc[W].fail;
    assign o_rsp.quotient = sc[W].fail ? '0 : FIELD_W'(sq[W]);

    `OCMD_ASSERT_IMPL(a_empty_moves, !o_rsp.valid, i_req.ready, "empty output must not stall")
    `OCMD_ASSERT_NEXT(a_stall_holds, o_rsp.valid && !o_rsp.ready,
        o_rsp.valid && $stable(o_rsp.quotient) && $stable(o_rsp.success),
        "stalled result changed")
    `OCMD_ASSERT_IMPL(a_zero_den_fails, o_rsp.valid && (sden[W] == '0), !o_rsp.success,
        "zero divisor reported success")
endmodule

>>> test/tb_overflow_checked_mul_div_u64_core.sv
module tb_overflow_checked_mul_div_u64_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ocmd_pkg::*;

    localparam int W = FIELD_W;
    localparam int LATENCY = 2 * W;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef logic [W-1:0] t_word;

    typedef struct {
        t_word quotient;
        logic  success;
    } t_scaled_result;

    // expected scaled quotients, oldest first
    class scaled_div_scoreboard;
        t_scaled_result pending[$];
        int errors;
        int matched;
        int failed_ops;

        // floor(val * mul / den) with overflow check, via 128-bit math
        function automatic t_scaled_result compute(t_word val, t_word mul, t_word den);
            t_scaled_result r;
            logic [2*W-1:0] prod;
            logic [2*W-1:0] quo;
            r.quotient = '0;
            r.success  = 1'b0;
            if (den != '0) begin
                prod = {{W{1'b0}}, val} * {{W{1'b0}}, mul};
                quo  = prod / {{W{1'b0}}, den};
                if (quo[2*W-1:W] == '0) begin
                    r.quotient = quo[W-1:0];
                    r.success  = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_operands(t_word val, t_word mul, t_word den);
            pending.push_back(compute(val, mul, den));
        endfunction

        function void check_result(t_word quotient, logic success);
            t_scaled_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result quotient=%h success=%b",
                         $time, quotient, success);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (!exp_r.success) failed_ops++;
            if (quotient !== exp_r.quotient) begin
                $display("%0t: quotient mismatch expected %h actual %h",
                         $time, exp_r.quotient, quotient);
                errors++;
            end
            if (success !== exp_r.success) begin
                $display("%0t: success mismatch expected %b actual %b",
                         $time, exp_r.success, success);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ocmd_req_if req_ch();
    ocmd_rsp_if rsp_ch();

    overflow_checked_mul_div_u64_core #(.DATA_WIDTH(W)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    scaled_div_scoreboard scoreboard;
    bit   stimulus_done;
    bit   long_stall_req;
    int   idle_cycles;
    int   sent_items;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // known values from time zero
    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.dividend_value = '0;
        req_ch.scale_multiplier = '0;
        req_ch.divisor = '0;
        rsp_ch.ready = 1'b0;
    end

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // operand with a random bit length, so small and large magnitudes both appear
    function automatic t_word rand_sized();
        t_word v;
        int bits;
        v = rand_word();
        bits = $urandom_range(W, 1);
        if (bits < W) v = v & ((t_word'(1) << bits) - 1);
        return v;
    endfunction

    // one operand transfer, after a random gap; valid stays high into a back-to-back transfer
    task automatic send_operands(t_word val, t_word mul, t_word den);
        int gap;
        gap = $urandom_range(6, 0);
        if (sent_items % 60 >= 45) gap = 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.dividend_value <= val;
        req_ch.scale_multiplier <= mul;
        req_ch.divisor <= den;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        scoreboard.note_operands(val, mul, den);
        sent_items++;
    endtask

    // near the overflow boundary: result close to 2^64
    task automatic send_boundary();
        t_word mul, den, val;
        mul = rand_sized() | 1;
        den = rand_sized() | 1;
        val = t_word'(({{W{1'b0}}, {W{1'b1}}} * {{W{1'b0}}, den}) / {{W{1'b0}}, mul});
        val = val + t_word'($urandom_range(4, 0)) - 2;
        send_operands(val, mul, den);
    endtask

    // stimulus
    initial begin
        t_word ones;
        int kind;
        ones = '1;
        scoreboard = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_operands(0, 0, 0);
        send_operands(ones, ones, 0);
        send_operands(0, ones, 1);
        send_operands(ones, 0, ones);
        send_operands(ones, 1, 1);
        send_operands(ones, ones, ones);
        send_operands(ones, 2, 1);
        send_operands(ones, ones, 1);
        send_operands(ones, ones - 1, ones);
        send_operands(ones - 1, ones, ones);
        send_operands(1, 1, ones);
        send_operands(ones, ones, 2);
        send_operands(64'h8000_0000_0000_0000, 2, 2);
        send_operands(64'h8000_0000_0000_0000, 2, 1);
        send_operands(64'h8000_0000_0000_0001, 64'hffff_fffe, 64'hffff_ffff);
        send_operands(7, 5, 3);
        send_operands(5, 7, 3);
        send_operands(1000, 3, 7);
        send_operands(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h1_0000_0000);
        send_operands(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, ones);

        // receiver holds off while operands keep flowing, filling the chain
        long_stall_req = 1'b1;
        repeat (LATENCY + 40) send_operands(rand_word(), rand_sized(), rand_word());
        long_stall_req = 1'b0;

        // random mix
        while (sent_items < 470) begin
            kind = $urandom_range(9, 0);
            case (kind)
                0: send_operands(rand_word(), rand_word(), 0);
                1, 2: send_boundary();
                3: send_operands(rand_word(), rand_word(), rand_word());
                default: send_operands(rand_sized(), rand_sized(), rand_sized());
            endcase
        end
        req_ch.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // result side: random stalls plus one long hold-off
    initial begin
        int stall;
        bit long_done;
        long_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_stall_req && !long_done) begin
                long_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LATENCY + 200) @(posedge i_clk);
            end
            stall = $urandom_range(6, 0);
            if (($urandom_range(3, 0) == 0)) stall = 0;
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            scoreboard.check_result(rsp_ch.quotient, rsp_ch.success);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // end of run
    initial begin
        idle_cycles = 0;
        stimulus_done = 1'b0;
        long_stall_req = 1'b0;
        sent_items = 0;
        @(posedge i_rst_n);
        while (!(stimulus_done && scoreboard.pending.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, scoreboard.pending.size());
            $display("FAILED: results differ");
        end else begin
            repeat (LATENCY + 20) @(posedge i_clk);
            $display("covered %0d operations, %0d checked, %0d with divisor zero or overflow",
                     sent_items, scoreboard.matched, scoreboard.failed_ops);
            if (scoreboard.errors == 0)
                $display("PASSED: all results match");
            else
                $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
